// ----- hw/rtl/plst_pkg.sv -----
// plst_pkg: shared types, operation and status codes for the positional list store
// used by the cell row, the core top level and the checker
// no dependencies
`default_nettype none

package plst_pkg;

	localparam int CAPACITY_DEF = 1024;
	localparam int DATA_WIDTH_DEF = 32;
	localparam int IDX_W = 17;
	localparam int MAX_DW = 64;

	localparam logic [3:0] OP_ADD_LAST = 4'd0;
	localparam logic [3:0] OP_ADD_FIRST = 4'd1;
	localparam logic [3:0] OP_ADD_MIDDLE = 4'd2;
	localparam logic [3:0] OP_DEL_FIRST = 4'd3;
	localparam logic [3:0] OP_DEL_LAST = 4'd4;
	localparam logic [3:0] OP_DEL_MIDDLE = 4'd5;
	localparam logic [3:0] OP_CLEAR = 4'd6;
	localparam logic [3:0] OP_CONTAINS = 4'd7;
	localparam logic [3:0] OP_GET = 4'd8;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic [3:0] operation;
		logic [31:0] value;
		logic [9:0] position;
		logic [10:0] count;
	} req_t;

	typedef struct packed {
		logic [31:0] data;
		logic found;
		logic [1:0] status;
		logic [10:0] fill;
	} rsp_t;

	typedef enum logic [2:0] {
		CM_HOLD,
		CM_INS,
		CM_DEL,
		CM_MATCH,
		CM_SEL,
		CM_REDUCE
	} cell_mode_t;

	typedef struct packed {
		cell_mode_t mode;
		logic [IDX_W-1:0] at;
		logic [IDX_W-1:0] fill;
		logic [MAX_DW-1:0] val;
	} cell_cmd_t;

endpackage

`default_nettype wire

// ----- hw/rtl/plst_stream_if.sv -----
// plst_stream_if: valid/ready channel carrying one payload per transaction
// payload type is set by the instantiating scope, usually from plst_pkg
`default_nettype none

interface plst_stream_if #(
	parameter type payload_t = logic
);
	logic valid;
	logic ready;
	payload_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/plst_cell.sv -----
// plst_cell: one list position, holds a word and a reduction lane
// shifts with its neighbors on insert and removal; depends on plst_pkg
`default_nettype none

module plst_cell #(
	parameter int INDEX = 0,
	parameter int DATA_WIDTH = plst_pkg::DATA_WIDTH_DEF,
	parameter int AW = 10
) (
	input wire logic clk,
	input wire plst_pkg::cell_cmd_t cmd,
	input wire logic [DATA_WIDTH-1:0] left_word,
	input wire logic [DATA_WIDTH-1:0] right_word,
	input wire logic [DATA_WIDTH-1:0] red_a,
	input wire logic [DATA_WIDTH-1:0] red_b,
	output logic [DATA_WIDTH-1:0] word_q,
	output logic [DATA_WIDTH-1:0] lane_q
);
	localparam logic [AW-1:0] IDX = AW'(INDEX);
	localparam logic [AW:0] IDXF = (AW+1)'(INDEX);

	logic [AW-1:0] at;
	logic [AW:0] fill;
	logic [DATA_WIDTH-1:0] val;

	assign at = cmd.at[AW-1:0];
	assign fill = cmd.fill[AW:0];
	assign val = cmd.val[DATA_WIDTH-1:0];

	always_ff @(posedge clk) begin
		case (cmd.mode)
			plst_pkg::CM_INS: begin
				if (IDX == at) begin
					word_q <= val;
				end else if (IDX > at) begin
					word_q <= left_word;
				end
			end
			plst_pkg::CM_DEL: begin
				if (IDX >= at) begin
					word_q <= right_word;
				end
			end
			plst_pkg::CM_MATCH: begin
				lane_q <= ((word_q == val) && (IDXF < fill)) ? DATA_WIDTH'(1) : '0;
			end
			plst_pkg::CM_SEL: begin
				lane_q <= (IDX == at) ? word_q : '0;
			end
			plst_pkg::CM_REDUCE: begin
				lane_q <= red_a | red_b;
			end
			default: begin
			end
		endcase
	end
endmodule

`default_nettype wire

// ----- hw/rtl/positional_list_store_core.sv -----
// positional_list_store_core: ordered word list held in a row of shifting cells
// insert, clear, end removal, out of range get and unknown op go exec then done; contains and in
// range get also pass the reduction state; front or middle removal with nonzero count and fill
// passes the shift state, one cell shift per cycle, one per removed word; one transaction in work
// at a time, next accepted while the previous result waits; reset clears fill count and control only
`default_nettype none

module positional_list_store_core #(
	parameter int CAPACITY = plst_pkg::CAPACITY_DEF,
	parameter int DATA_WIDTH = plst_pkg::DATA_WIDTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	plst_stream_if.sink req,
	plst_stream_if.source rsp
);
	localparam int AW = $clog2(CAPACITY);
	localparam int FW = AW + 1;
	localparam int SW = ((FW > 11) ? FW : 11) + 2;
	localparam int CW = $clog2(AW + 1);
	localparam logic [FW-1:0] CAP_F = FW'(CAPACITY);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SHIFT,
		S_REDUCE,
		S_DONE
	} state_t;

	state_t state_q;
	logic [3:0] op_q;
	logic [DATA_WIDTH-1:0] val_q;
	logic [9:0] pos_q;
	logic [10:0] cnt_q;
	logic [FW-1:0] fill_q;
	logic [AW-1:0] s_q;
	logic [FW-1:0] n_q;
	logic [CW-1:0] red_cnt_q;
	logic [1:0] res_status_q;
	logic out_valid_q;
	plst_pkg::rsp_t out_q;

	plst_pkg::cell_cmd_t cmd;
	logic [DATA_WIDTH-1:0] word_a [CAPACITY];
	logic [DATA_WIDTH-1:0] lane_a [CAPACITY];

	logic full;
	logic get_ok;
	logic signed [SW-1:0] fill_s;
	logic signed [SW-1:0] cnt_s;
	logic signed [SW-1:0] s_raw;
	logic signed [SW-1:0] e_raw;
	logic signed [SW-1:0] s_clip;
	logic signed [SW-1:0] e_clip;
	logic [FW-1:0] fill_m1;
	logic [FW-1:0] last_fill;
	logic [AW-1:0] ins_at;

	assign full = (fill_q >= CAP_F);
	assign fill_m1 = fill_q - FW'(1);
	assign fill_s = $signed(SW'(fill_q));
	assign cnt_s = $signed(SW'(cnt_q));
	assign get_ok = ($signed(SW'(pos_q)) < fill_s);
	assign s_raw = (op_q == plst_pkg::OP_DEL_MIDDLE)
		? ($signed(SW'(fill_m1 >> 1)) - $signed(SW'(cnt_q >> 1))) : '0;
	assign e_raw = s_raw + cnt_s;
	assign s_clip = (s_raw < 0) ? '0 : s_raw;
	assign e_clip = (e_raw > fill_s) ? fill_s : e_raw;
	assign last_fill = (cnt_s >= fill_s) ? '0 : FW'(fill_s - cnt_s);

	always_comb begin
		case (op_q)
			plst_pkg::OP_ADD_FIRST: ins_at = '0;
			plst_pkg::OP_ADD_MIDDLE: ins_at = AW'(fill_q >> 1);
			default: ins_at = AW'(fill_q);
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.mode = plst_pkg::CM_HOLD;
		cmd.fill = plst_pkg::IDX_W'(fill_q);
		cmd.val = plst_pkg::MAX_DW'(val_q);
		unique case (state_q)
			S_EXEC: begin
				case (op_q) inside
					plst_pkg::OP_ADD_LAST, plst_pkg::OP_ADD_FIRST,
					plst_pkg::OP_ADD_MIDDLE: begin
						if (!full) begin
							cmd.mode = plst_pkg::CM_INS;
							cmd.at = plst_pkg::IDX_W'(ins_at);
						end
					end
					plst_pkg::OP_CONTAINS: cmd.mode = plst_pkg::CM_MATCH;
					plst_pkg::OP_GET: begin
						cmd.mode = plst_pkg::CM_SEL;
						cmd.at = plst_pkg::IDX_W'(pos_q);
					end
					default: begin
					end
				endcase
			end
			S_SHIFT: begin
				cmd.mode = plst_pkg::CM_DEL;
				cmd.at = plst_pkg::IDX_W'(s_q);
			end
			S_REDUCE: cmd.mode = plst_pkg::CM_REDUCE;
			default: begin
			end
		endcase
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] left_w;
		logic [DATA_WIDTH-1:0] right_w;
		logic [DATA_WIDTH-1:0] ra;
		logic [DATA_WIDTH-1:0] rb;

		if (i == 0) begin : g_l0
			assign left_w = '0;
		end else begin : g_l
			assign left_w = word_a[i-1];
		end
		if (i == CAPACITY - 1) begin : g_r0
			assign right_w = '0;
		end else begin : g_r
			assign right_w = word_a[i+1];
		end
		if (2 * i < CAPACITY) begin : g_a
			assign ra = lane_a[2*i];
		end else begin : g_a0
			assign ra = '0;
		end
		if (2 * i + 1 < CAPACITY) begin : g_b
			assign rb = lane_a[2*i+1];
		end else begin : g_b0
			assign rb = '0;
		end

		plst_cell #(
			.INDEX(i),
			.DATA_WIDTH(DATA_WIDTH),
			.AW(AW)
		) u_cell (
			.clk(clk),
			.cmd(cmd),
			.left_word(left_w),
			.right_word(right_w),
			.red_a(ra),
			.red_b(rb),
			.word_q(word_a[i]),
			.lane_q(lane_a[i])
		);
	end

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = out_valid_q;
	assign rsp.payload = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q <= '0;
			out_valid_q <= 1'b0;
			res_status_q <= plst_pkg::ST_OK;
			red_cnt_q <= '0;
			n_q <= '0;
		end else begin
			if (out_valid_q && rsp.ready && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						op_q <= req.payload.operation;
						val_q <= DATA_WIDTH'(req.payload.value);
						pos_q <= req.payload.position;
						cnt_q <= req.payload.count;
						res_status_q <= plst_pkg::ST_OK;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_DONE;
					case (op_q) inside
						plst_pkg::OP_ADD_LAST, plst_pkg::OP_ADD_FIRST,
						plst_pkg::OP_ADD_MIDDLE: begin
							if (full) begin
								res_status_q <= plst_pkg::ST_FULL;
							end else begin
								fill_q <= fill_q + FW'(1);
							end
						end
						plst_pkg::OP_DEL_FIRST, plst_pkg::OP_DEL_MIDDLE: begin
							if ((cnt_q != '0) && (fill_q != '0)) begin
								s_q <= AW'(s_clip);
								n_q <= FW'(e_clip - s_clip);
								state_q <= S_SHIFT;
							end
						end
						plst_pkg::OP_DEL_LAST: begin
							if (cnt_q != '0) begin
								fill_q <= last_fill;
							end
						end
						plst_pkg::OP_CLEAR: fill_q <= '0;
						plst_pkg::OP_CONTAINS: begin
							red_cnt_q <= '0;
							state_q <= S_REDUCE;
						end
						plst_pkg::OP_GET: begin
							if (get_ok) begin
								red_cnt_q <= '0;
								state_q <= S_REDUCE;
							end else begin
								res_status_q <= plst_pkg::ST_RANGE;
							end
						end
						default: begin
						end
					endcase
				end
				S_SHIFT: begin
					fill_q <= fill_q - FW'(1);
					n_q <= n_q - FW'(1);
					if (n_q == FW'(1)) begin
						state_q <= S_DONE;
					end
				end
				S_REDUCE: begin
					red_cnt_q <= red_cnt_q + CW'(1);
					if (red_cnt_q == CW'(AW - 1)) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_valid_q || rsp.ready) begin
						out_valid_q <= 1'b1;
						out_q.data <= ((op_q == plst_pkg::OP_GET)
							&& (res_status_q == plst_pkg::ST_OK)) ? 32'(lane_a[0]) : '0;
						out_q.found <= (op_q == plst_pkg::OP_CONTAINS) & lane_a[0][0];
						out_q.status <= res_status_q;
						out_q.fill <= 11'(fill_q);
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

`default_nettype wire

// ----- hw/rtl/plst_checker.sv -----
// plst_checker: port-level assertions on the positional list store core
// bound to positional_list_store_core; depends on plst_pkg
`default_nettype none

module plst_checker #(
	parameter int CAPACITY = plst_pkg::CAPACITY_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic rsp_valid,
	input wire logic rsp_ready,
	input wire plst_pkg::rsp_t rsp_payload
);
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result dropped while stalled");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_payload.status != 2'd3)
		else $error("undefined status code");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (CAPACITY > 2047) || (32'(rsp_payload.fill) <= CAPACITY))
		else $error("fill beyond capacity");

	a_found_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_payload.found |->
		rsp_payload.status == plst_pkg::ST_OK && rsp_payload.data == '0)
		else $error("found with data or error status");

	a_full_fill: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_payload.status == plst_pkg::ST_FULL |->
		rsp_payload.fill == 11'(CAPACITY))
		else $error("full status with list not full");
endmodule

bind positional_list_store_core plst_checker #(
	.CAPACITY(CAPACITY)
) u_plst_checker (
	.clk(clk),
	.arst_n(arst_n),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.rsp_payload(rsp.payload)
);

`default_nettype wire

// ----- sim/tb.sv -----
// tb: self-checking bench for positional_list_store_core, random and directed list operations
// depends on plst_pkg, plst_stream_if and the core rtl
`timescale 1ns / 1ps

module tb;
	localparam int CAP = 1024;
	localparam int WATCHDOG_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	plst_stream_if #(.payload_t(plst_pkg::req_t)) req_ch ();
	plst_stream_if #(.payload_t(plst_pkg::rsp_t)) rsp_ch ();

	positional_list_store_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch.sink),
		.rsp(rsp_ch.source)
	);

	always #1 clk = ~clk;

	plst_pkg::req_t pending_ops[$];
	plst_pkg::rsp_t expected_rsps[$];
	logic [31:0] list_words[$];
	int errors = 0;
	int idle_cycles = 0;
	bit req_taken = 0;
	bit calm = 0;

	function automatic plst_pkg::rsp_t apply_op(plst_pkg::req_t r);
		plst_pkg::rsp_t o;
		int s, e, n;
		o = '0;
		n = list_words.size();
		case (r.operation)
			plst_pkg::OP_ADD_LAST, plst_pkg::OP_ADD_FIRST, plst_pkg::OP_ADD_MIDDLE: begin
				if (n >= CAP) o.status = plst_pkg::ST_FULL;
				else if (r.operation == plst_pkg::OP_ADD_LAST) list_words.push_back(r.value);
				else if (r.operation == plst_pkg::OP_ADD_FIRST) list_words.push_front(r.value);
				else list_words.insert(n / 2, r.value);
			end
			plst_pkg::OP_DEL_FIRST: begin
				for (int i = 0; i < r.count && list_words.size() > 0; i++)
					void'(list_words.pop_front());
			end
			plst_pkg::OP_DEL_LAST: begin
				for (int i = 0; i < r.count && list_words.size() > 0; i++)
					void'(list_words.pop_back());
			end
			plst_pkg::OP_DEL_MIDDLE: begin
				if (r.count != 0 && n != 0) begin
					s = (n - 1) / 2 - r.count / 2;
					e = s + r.count;
					if (s < 0) s = 0;
					if (e > n) e = n;
					for (int i = s; i < e; i++) list_words.delete(s);
				end
			end
			plst_pkg::OP_CLEAR: list_words.delete();
			plst_pkg::OP_CONTAINS: begin
				foreach (list_words[i]) if (list_words[i] == r.value) o.found = 1'b1;
			end
			plst_pkg::OP_GET: begin
				if (r.position < n) o.data = list_words[r.position];
				else o.status = plst_pkg::ST_RANGE;
			end
			default: ;
		endcase
		o.fill = 11'(list_words.size());
		return o;
	endfunction

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 3))
			0: return 32'h0;
			1: return 32'hffff_ffff;
			2: return $urandom_range(0, 7);
			default: return $urandom;
		endcase
	endfunction

	function automatic plst_pkg::req_t make_op(logic [3:0] op, logic [31:0] v,
			logic [9:0] p, logic [10:0] c);
		plst_pkg::req_t r;
		r.operation = op;
		r.value = v;
		r.position = p;
		r.count = c;
		return r;
	endfunction

	// driver, holds a transaction until it is taken
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.payload <= '0;
		end else begin
			if (req_ch.valid && !req_taken) begin
				req_ch.valid <= 1'b1;
			end else if (pending_ops.size() > 0 && (calm || $urandom_range(0, 99) >= 17)) begin
				req_ch.valid <= 1'b1;
				req_ch.payload <= pending_ops[0];
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// stall on the response side
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) rsp_ch.ready <= 1'b0;
		else rsp_ch.ready <= calm || $urandom_range(0, 99) >= 17;
	end

	// monitor and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			req_taken <= req_ch.valid && req_ch.ready;
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_rsps.size() == 0) begin
					$error("response with nothing expected");
					errors++;
				end else begin
					if (rsp_ch.payload.data !== expected_rsps[0].data) begin
						$error("data exp %h got %h", expected_rsps[0].data,
							rsp_ch.payload.data);
						errors++;
					end
					if (rsp_ch.payload.found !== expected_rsps[0].found) begin
						$error("found exp %0d got %0d", expected_rsps[0].found,
							rsp_ch.payload.found);
						errors++;
					end
					if (rsp_ch.payload.status !== expected_rsps[0].status) begin
						$error("status exp %0d got %0d", expected_rsps[0].status,
							rsp_ch.payload.status);
						errors++;
					end
					if (rsp_ch.payload.fill !== expected_rsps[0].fill) begin
						$error("fill exp %0d got %0d", expected_rsps[0].fill,
							rsp_ch.payload.fill);
						errors++;
					end
					void'(expected_rsps.pop_front());
				end
			end
			if (req_ch.valid && req_ch.ready) begin
				expected_rsps.push_back(apply_op(req_ch.payload));
				void'(pending_ops.pop_front());
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin
		int pick, op;
		// directed: empty list cases, extremes, every operation
		pending_ops.push_back(make_op(plst_pkg::OP_GET, 0, 0, 0));
		pending_ops.push_back(make_op(plst_pkg::OP_DEL_FIRST, 0, 0, 5));
		pending_ops.push_back(make_op(plst_pkg::OP_DEL_MIDDLE, 0, 0, 5));
		pending_ops.push_back(make_op(plst_pkg::OP_DEL_LAST, 0, 0, 5));
		pending_ops.push_back(make_op(plst_pkg::OP_CONTAINS, 32'h0, 0, 0));
		pending_ops.push_back(make_op(plst_pkg::OP_ADD_LAST, 32'hffff_ffff, 0, 0));
		pending_ops.push_back(make_op(plst_pkg::OP_ADD_FIRST, 32'h0, 0, 0));
		pending_ops.push_back(make_op(plst_pkg::OP_ADD_MIDDLE, 32'h1234_5678, 0, 0));
		pending_ops.push_back(make_op(plst_pkg::OP_ADD_LAST, 32'hedcb_a987, 0, 0));
		pending_ops.push_back(make_op(plst_pkg::OP_GET, 0, 2, 0));
		pending_ops.push_back(make_op(plst_pkg::OP_GET, 0, 10'h3ff, 0));
		pending_ops.push_back(make_op(plst_pkg::OP_CONTAINS, 32'hffff_ffff, 0, 0));
		pending_ops.push_back(make_op(plst_pkg::OP_CONTAINS, 32'h5555_5555, 0, 0));
		pending_ops.push_back(make_op(plst_pkg::OP_DEL_FIRST, 0, 0, 0));
		pending_ops.push_back(make_op(plst_pkg::OP_DEL_MIDDLE, 0, 0, 1));
		pending_ops.push_back(make_op(plst_pkg::OP_DEL_MIDDLE, 0, 0, 11'h7ff));
		pending_ops.push_back(make_op(4'hf, 32'hffff_ffff, 10'h3ff, 11'h7ff));
		pending_ops.push_back(make_op(4'd9, 0, 0, 0));
		for (int i = 0; i < 4; i++)
			pending_ops.push_back(make_op(plst_pkg::OP_ADD_LAST, i, 0, 0));
		pending_ops.push_back(make_op(plst_pkg::OP_DEL_LAST, 0, 0, 11'd1024));
		pending_ops.push_back(make_op(plst_pkg::OP_ADD_LAST, 7, 0, 0));
		pending_ops.push_back(make_op(plst_pkg::OP_CLEAR, 0, 0, 0));
		// random with a bias toward growing lists of small size
		for (int i = 0; i < 680; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) op = $urandom_range(0, 2);
			else if (pick < 60) op = $urandom_range(3, 5);
			else if (pick < 62) op = plst_pkg::OP_CLEAR;
			else if (pick < 78) op = plst_pkg::OP_CONTAINS;
			else if (pick < 98) op = plst_pkg::OP_GET;
			else op = $urandom_range(9, 15);
			pending_ops.push_back(make_op(4'(op), rand_word(),
				($urandom_range(0, 9) == 0) ? 10'($urandom) : 10'($urandom_range(0, 40)),
				($urandom_range(0, 19) == 0) ? 11'($urandom_range(0, 2047))
					: 11'($urandom_range(0, 6))));
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		fork
			begin
				repeat (3000) @(posedge clk);
				calm = 1;
				repeat (1500) @(posedge clk);
				calm = 0;
			end
		join_none
		wait (pending_ops.size() == 0 && expected_rsps.size() == 0);
		repeat (1100) @(posedge clk);
		if (errors == 0 && expected_rsps.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule
